>>> rtl/split_elastic_stress_energy_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the split elastic stress and energy block
// Short forms for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SPLIT_ELASTIC_STRESS_ENERGY_DEFINES_SVH
`define SPLIT_ELASTIC_STRESS_ENERGY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SES_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SES_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ses_pkg.sv
// ----------------------------------------------------------------------------
// ses_pkg
// Types, widths and fixed-point helpers for the split elastic stress block.
// ----------------------------------------------------------------------------
`default_nettype none

package ses_pkg;

	// Port payload types
	typedef logic signed [31:0] strain_t;
	typedef logic [16:0]        degr_t;
	typedef logic [31:0]        modulus_t;
	typedef logic signed [47:0] stress_t;
	typedef logic [47:0]        energy_t;
	typedef logic [1:0]         reg_idx_t;
	typedef logic [31:0]        cfg_data_t;

	// Register indexes
	localparam reg_idx_t REG_SHEAR = 2'd0;
	localparam reg_idx_t REG_BULK  = 2'd1;
	localparam reg_idx_t REG_SPLIT = 2'd2;

	// Pipeline depth (register stages, output register included)
	localparam int SES_DEPTH = 8;

	// Internal widths
	localparam int STRAIN_W = 32;
	localparam int OUT_W    = 48;
	localparam int TR_W     = 34;              // trace and deviator, Q.30
	localparam int CV_W     = 49;              // g*K and g*G
	localparam int LO_W     = 25;              // low slice of a 49-bit coefficient
	localparam int HI_W     = CV_W - LO_W;
	localparam int PL_W     = TR_W + LO_W + 1; // 34-bit value times low slice
	localparam int PH_W     = TR_W + HI_W + 1;
	localparam int SL_W     = STRAIN_W + LO_W + 1;
	localparam int SH_W     = STRAIN_W + HI_W + 1;
	localparam int SQ_W     = 66;              // squares of trace and deviator
	localparam int SHSQ_W   = 64;              // squares of shear strain
	localparam int SUMSQ_W  = 68;              // dev:dev, Q.60
	localparam int TQ_CH    = 22;              // trace-square slice
	localparam int PK_W     = TQ_CH + 32;
	localparam int SQ_CH    = 23;              // dev:dev slice
	localparam int PE_W     = SQ_CH + 32;
	localparam int ST_W     = 86;              // stress sum, Q.54
	localparam int ST_RW    = ST_W + 1;
	localparam int ST_RND   = 38;
	localparam int EN_W     = 103;             // energy sum, Q.69
	localparam int EN_RND   = 53;

	// floor(m/3) = (m * RECIP3) >> 36 for m below 2^34
	localparam int          RECIP_SH = 36;
	localparam logic [34:0] RECIP3   = 35'd22906492246;
	// tr + 1 + 3*2^31 keeps the dividend non-negative
	localparam logic [TR_W-1:0]        M_OFFSET = 34'd6442450945;
	localparam logic signed [TR_W-1:0] Q_BIAS   = 34'sd2147483648;

	localparam stress_t STRESS_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam stress_t STRESS_MIN = 48'sh8000_0000_0000;

	// Round Q.54 half up to Q.16 and saturate to 48 signed bits.
	function automatic stress_t sat_stress(input logic signed [ST_W-1:0] v);
		logic signed [ST_RW-1:0] r;
		stress_t                 res;
		r = ST_RW'(v) + (ST_RW'(1) << (ST_RND - 1));
		if (r[ST_RW-1] == r[ST_W-1])
			res = r[ST_W-1:ST_RND];
		else if (r[ST_RW-1])
			res = STRESS_MIN;
		else
			res = STRESS_MAX;
		return res;
	endfunction

	// Take a rounded Q.69 sum to Q.16 and saturate to 48 unsigned bits.
	function automatic energy_t sat_energy(input logic [EN_W-1:0] v);
		energy_t res;
		if (|v[EN_W-1:EN_RND+OUT_W])
			res = '1;
		else
			res = v[EN_RND+OUT_W-1:EN_RND];
		return res;
	endfunction

endpackage

`default_nettype wire

>>> rtl/split_elastic_stress_energy.sv
// ----------------------------------------------------------------------------
// split_elastic_stress_energy
// Volumetric/deviatoric split stress and crack-driving energy per point.
// ----------------------------------------------------------------------------
// Takes one quadrature point per clock while point_stall is low and returns
// its six stress components and its history-maxed energy from the output
// register, one result per point, in order. The eight register stages form an
// elastic pipeline: each stage loads whenever it is empty or the stage after
// it moves, so bubbles close up and point_stall rises only when all eight
// stages hold a result and result_stall is high. The stages follow the
// multiplier chain: the divide-by-three reciprocal and the coefficient
// products share a stage, and the sliced wide products and the final energy
// sum take their own stages. Moduli and the split flag are read straight from
// the configuration registers, so write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module split_elastic_stress_energy (
	input  wire               clk,
	input  wire               arst_n,
	// configuration
	input  wire               cfg_write,
	input  ses_pkg::reg_idx_t cfg_index,
	input  ses_pkg::cfg_data_t cfg_data,
	// point channel
	input  wire               point_valid,
	output logic              point_stall,
	input  ses_pkg::strain_t  strain_xx,
	input  ses_pkg::strain_t  strain_yy,
	input  ses_pkg::strain_t  strain_zz,
	input  ses_pkg::strain_t  strain_xy,
	input  ses_pkg::strain_t  strain_yz,
	input  ses_pkg::strain_t  strain_xz,
	input  ses_pkg::degr_t    degradation,
	input  ses_pkg::energy_t  old_energy,
	// result channel
	output logic              result_valid,
	input  wire               result_stall,
	output ses_pkg::stress_t  stress_xx,
	output ses_pkg::stress_t  stress_yy,
	output ses_pkg::stress_t  stress_zz,
	output ses_pkg::stress_t  stress_xy,
	output ses_pkg::stress_t  stress_yz,
	output ses_pkg::stress_t  stress_xz,
	output ses_pkg::energy_t  energy
);
	import ses_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	modulus_t shear_q;
	modulus_t bulk_q;
	logic     split_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shear_q <= '0;
			bulk_q  <= '0;
			split_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SHEAR: shear_q <= cfg_data;
				REG_BULK:  bulk_q  <= cfg_data;
				REG_SPLIT: split_q <= cfg_data[0];
				default: begin
					// no register at this index: drop the write
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Valid chain. A stage takes new data when it is empty or when the
	// stage downstream of it advances in the same cycle.
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6, ld_s7, ld_s8;

	assign rdy_s8 = !vld_s8 || !result_stall;
	assign rdy_s7 = !vld_s7 || rdy_s8;
	assign rdy_s6 = !vld_s6 || rdy_s7;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign ld_s1 = rdy_s1 && point_valid;
	assign ld_s2 = rdy_s2 && vld_s1;
	assign ld_s3 = rdy_s3 && vld_s2;
	assign ld_s4 = rdy_s4 && vld_s3;
	assign ld_s5 = rdy_s5 && vld_s4;
	assign ld_s6 = rdy_s6 && vld_s5;
	assign ld_s7 = rdy_s7 && vld_s6;
	assign ld_s8 = rdy_s8 && vld_s7;

	assign point_stall  = !rdy_s1;
	assign result_valid = vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= point_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
			if (rdy_s8) vld_s8 <= vld_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: capture the point, form the trace and the offset dividend
	// for the divide by three.
	// ------------------------------------------------------------------
	logic signed [TR_W-1:0] tr_c;
	logic [TR_W-1:0]        m_c;

	always_comb begin
		tr_c = TR_W'(strain_xx) + TR_W'(strain_yy) + TR_W'(strain_zz);
		m_c  = $unsigned(tr_c) + M_OFFSET;
	end

	strain_t                dgn_s1 [3];
	strain_t                shr_s1 [3];
	degr_t                  g_s1;
	energy_t                old_s1;
	logic signed [TR_W-1:0] tr_s1;
	logic [TR_W-1:0]        m_s1;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			dgn_s1[0] <= strain_xx;
			dgn_s1[1] <= strain_yy;
			dgn_s1[2] <= strain_zz;
			shr_s1[0] <= strain_xy;
			shr_s1[1] <= strain_yz;
			shr_s1[2] <= strain_xz;
			g_s1      <= degradation;
			old_s1    <= old_energy;
			tr_s1     <= tr_c;
			m_s1      <= m_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: reciprocal multiply for tr/3, the two degraded moduli, the
	// trace square (positive trace only) and the shear squares.
	// ------------------------------------------------------------------
	localparam int QP_W = TR_W + 35;

	logic [QP_W-1:0] qprod_c;
	logic            tr_pos_s1;

	assign qprod_c   = QP_W'(m_s1) * QP_W'(RECIP3);
	assign tr_pos_s1 = !tr_s1[TR_W-1] && (tr_s1 != '0);

	strain_t                dgn_s2 [3];
	strain_t                shr_s2 [3];
	energy_t                old_s2;
	logic signed [TR_W-1:0] tr_s2;
	logic [31:0]            qoff_s2;
	logic [CV_W-1:0]        cv_s2;
	logic [CV_W-1:0]        gg_s2;
	logic [SQ_W-1:0]        trsq_s2;
	logic [SHSQ_W-1:0]      shsq_s2 [3];

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			dgn_s2  <= dgn_s1;
			shr_s2  <= shr_s1;
			old_s2  <= old_s1;
			tr_s2   <= tr_s1;
			qoff_s2 <= qprod_c[RECIP_SH+31:RECIP_SH];
			// a non-positive trace keeps the full bulk modulus in split mode
			if (split_q && !tr_pos_s1)
				cv_s2 <= CV_W'({bulk_q, 16'h0000});
			else
				cv_s2 <= CV_W'(g_s1) * CV_W'(bulk_q);
			gg_s2 <= CV_W'(g_s1) * CV_W'(shear_q);
			if (tr_pos_s1)
				trsq_s2 <= SQ_W'(tr_s1[TR_W-2:0]) * SQ_W'(tr_s1[TR_W-2:0]);
			else
				trsq_s2 <= '0;
			for (int j = 0; j < 3; j++)
				shsq_s2[j] <= $unsigned(SHSQ_W'(shr_s1[j]) * SHSQ_W'(shr_s1[j]));
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: deviator, and the first sliced products of the volumetric
	// stress, the shear stress and K*tr^2.
	// ------------------------------------------------------------------
	logic signed [TR_W-1:0] dev_s3 [3];
	logic signed [PL_W-1:0] pvl_s3;
	logic signed [PH_W-1:0] pvh_s3;
	logic signed [SL_W-1:0] psl_s3 [3];
	logic signed [SH_W-1:0] psh_s3 [3];
	logic [PK_W-1:0]        pk_s3 [3];
	logic [SHSQ_W+1:0]      shsum_s3;
	logic [CV_W-1:0]        gg_s3;
	energy_t                old_s3;

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			// dev = e - q, with q = qoff - 2^31
			for (int i = 0; i < 3; i++)
				dev_s3[i] <= TR_W'(dgn_s2[i]) - $signed({2'b00, qoff_s2}) + Q_BIAS;
			pvl_s3 <= PL_W'(tr_s2) * PL_W'($signed({1'b0, cv_s2[LO_W-1:0]}));
			pvh_s3 <= PH_W'(tr_s2) * PH_W'($signed({1'b0, cv_s2[CV_W-1:LO_W]}));
			for (int j = 0; j < 3; j++) begin
				psl_s3[j] <= SL_W'(shr_s2[j]) * SL_W'($signed({1'b0, gg_s2[LO_W-1:0]}));
				psh_s3[j] <= SH_W'(shr_s2[j]) * SH_W'($signed({1'b0, gg_s2[CV_W-1:LO_W]}));
			end
			for (int k = 0; k < 3; k++)
				pk_s3[k] <= PK_W'(TQ_CH'(trsq_s2 >> (k * TQ_CH))) * PK_W'(bulk_q);
			shsum_s3 <= (SHSQ_W+2)'(shsq_s2[0]) + (SHSQ_W+2)'(shsq_s2[1])
				+ (SHSQ_W+2)'(shsq_s2[2]);
			gg_s3  <= gg_s2;
			old_s3 <= old_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: deviator products and squares; assemble the volumetric
	// term, shear stress sums and K*tr^2.
	// ------------------------------------------------------------------
	localparam int DSQ_PW = 2 * TR_W;

	logic signed [DSQ_PW-1:0] dsq_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			dsq_c[i] = DSQ_PW'(dev_s3[i]) * DSQ_PW'(dev_s3[i]);
	end

	logic signed [PL_W-1:0] pdl_s4 [3];
	logic signed [PH_W-1:0] pdh_s4 [3];
	logic [SQ_W-1:0]        dsq_s4 [3];
	logic signed [ST_W-1:0] vol_s4;
	logic signed [ST_W-1:0] shst_s4 [3];
	logic [EN_W-1:0]        kt_s4;
	logic [SHSQ_W+1:0]      shsum_s4;
	energy_t                old_s4;

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			for (int i = 0; i < 3; i++) begin
				pdl_s4[i] <= PL_W'(dev_s3[i]) * PL_W'($signed({1'b0, gg_s3[LO_W-1:0]}));
				pdh_s4[i] <= PH_W'(dev_s3[i]) * PH_W'($signed({1'b0, gg_s3[CV_W-1:LO_W]}));
				dsq_s4[i] <= $unsigned(dsq_c[i][SQ_W-1:0]);
			end
			vol_s4 <= (ST_W'(pvh_s3) <<< LO_W) + ST_W'(pvl_s3);
			// shear stress is 2*g*G*e
			for (int j = 0; j < 3; j++)
				shst_s4[j] <= (ST_W'(psh_s3[j]) <<< (LO_W + 1)) + (ST_W'(psl_s3[j]) <<< 1);
			kt_s4 <= EN_W'(pk_s3[0]) + (EN_W'(pk_s3[1]) << TQ_CH)
				+ (EN_W'(pk_s3[2]) << (2 * TQ_CH));
			shsum_s4 <= shsum_s3;
			old_s4   <= old_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: diagonal stress sums, shear stress rounding, dev:dev.
	// ------------------------------------------------------------------
	logic signed [ST_W-1:0] dst_s5 [3];
	stress_t                shout_s5 [3];
	logic [SUMSQ_W-1:0]     sumsq_s5;
	logic [EN_W-1:0]        kt_s5;
	energy_t                old_s5;

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			for (int i = 0; i < 3; i++)
				dst_s5[i] <= vol_s4 + (ST_W'(pdh_s4[i]) <<< (LO_W + 1))
					+ (ST_W'(pdl_s4[i]) <<< 1);
			for (int j = 0; j < 3; j++)
				shout_s5[j] <= sat_stress(shst_s4[j]);
			// shear entries count twice in dev:dev
			sumsq_s5 <= SUMSQ_W'(dsq_s4[0]) + SUMSQ_W'(dsq_s4[1]) + SUMSQ_W'(dsq_s4[2])
				+ (SUMSQ_W'(shsum_s4) << 1);
			kt_s5  <= kt_s4;
			old_s5 <= old_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: diagonal stress rounding, sliced G*(dev:dev).
	// ------------------------------------------------------------------
	stress_t         dgout_s6 [3];
	stress_t         shout_s6 [3];
	logic [PE_W-1:0] pe_s6 [3];
	logic [EN_W-1:0] kt_s6;
	energy_t         old_s6;

	always_ff @(posedge clk) begin
		if (ld_s6) begin
			for (int i = 0; i < 3; i++)
				dgout_s6[i] <= sat_stress(dst_s5[i]);
			shout_s6 <= shout_s5;
			for (int k = 0; k < 3; k++)
				pe_s6[k] <= PE_W'(SQ_CH'(sumsq_s5 >> (k * SQ_CH))) * PE_W'(shear_q);
			kt_s6  <= kt_s5;
			old_s6 <= old_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: energy sum 2*G*(dev:dev) + K*tr^2 plus the rounding half.
	// ------------------------------------------------------------------
	logic [EN_W-1:0] esum_s7;
	stress_t         dgout_s7 [3];
	stress_t         shout_s7 [3];
	energy_t         old_s7;

	always_ff @(posedge clk) begin
		if (ld_s7) begin
			esum_s7 <= ((EN_W'(pe_s6[0]) + (EN_W'(pe_s6[1]) << SQ_CH)
				+ (EN_W'(pe_s6[2]) << (2 * SQ_CH))) << 1)
				+ kt_s6 + (EN_W'(1) << (EN_RND - 1));
			dgout_s7 <= dgout_s6;
			shout_s7 <= shout_s6;
			old_s7   <= old_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: output register. Saturate the energy, hold it at the
	// history value or above.
	// ------------------------------------------------------------------
	energy_t en_c;

	assign en_c = sat_energy(esum_s7);

	stress_t dgout_s8 [3];
	stress_t shout_s8 [3];
	energy_t energy_s8;

	always_ff @(posedge clk) begin
		if (ld_s8) begin
			dgout_s8  <= dgout_s7;
			shout_s8  <= shout_s7;
			energy_s8 <= (en_c < old_s7) ? old_s7 : en_c;
		end
	end

	assign stress_xx = dgout_s8[0];
	assign stress_yy = dgout_s8[1];
	assign stress_zz = dgout_s8[2];
	assign stress_xy = shout_s8[0];
	assign stress_yz = shout_s8[1];
	assign stress_xz = shout_s8[2];
	assign energy    = energy_s8;

endmodule

`default_nettype wire

>>> rtl/ses_checker.sv
// ----------------------------------------------------------------------------
// ses_checker
// Port-level checks on occupancy, back-pressure and result hold.
// ----------------------------------------------------------------------------
`default_nettype none

`include "split_elastic_stress_energy_defines.svh"

module ses_checker (
	input wire              clk,
	input wire              arst_n,
	input wire              point_valid,
	input wire              point_stall,
	input wire              result_valid,
	input wire              result_stall,
	input ses_pkg::stress_t stress_xx,
	input ses_pkg::energy_t energy
);
	import ses_pkg::*;

	localparam int CNT_W = $clog2(SES_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(SES_DEPTH);

	logic             in_xfer;
	logic             out_xfer;
	logic [CNT_W-1:0] inflight_q;

	assign in_xfer  = point_valid && !point_stall;
	assign out_xfer = result_valid && !result_stall;

	// points accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({in_xfer, out_xfer})
				2'b10:   inflight_q <= inflight_q + CNT_W'(1);
				2'b01:   inflight_q <= inflight_q - CNT_W'(1);
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	`SES_ASSERT_NOW(a_no_phantom, clk, arst_n, result_valid, inflight_q != '0, "result without a point in flight")
	`SES_ASSERT_NOW(a_take_when_room, clk, arst_n, inflight_q < FULL, !point_stall, "point stalled with a free stage")
	`SES_ASSERT_NOW(a_stall_when_full, clk, arst_n, (inflight_q == FULL) && result_stall, point_stall, "point taken into a full, stalled pipeline")
	`SES_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(energy) && $stable(stress_xx), "stalled result changed")

endmodule

bind split_elastic_stress_energy ses_checker u_ses_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.point_valid  (point_valid),
	.point_stall  (point_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.stress_xx    (stress_xx),
	.energy       (energy)
);

`default_nettype wire

>>> tb/sv/stress_energy_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// Stress and energy scoreboard
// Mirrors the moduli and split flag, works out the stress components and the
// history-maxed energy of every accepted point, and checks results in order.
// ----------------------------------------------------------------------------
package stress_energy_scoreboard_pkg;

	import ses_pkg::*;

	typedef struct {
		strain_t strain [6];  // xx, yy, zz, xy, yz, xz
		degr_t   degr;
		energy_t old_energy;
	} point_t;

	typedef struct {
		stress_t stress [6];  // xx, yy, zz, xy, yz, xz
		energy_t energy;
	} response_t;

	localparam int REPORT_CAP = 100;

	class stress_energy_scoreboard;

		modulus_t  shear_mod;
		modulus_t  bulk_mod;
		logic      split_on;
		response_t due_responses [$];
		int        errors;

		function new();
			shear_mod = '0;
			bulk_mod  = '0;
			split_on  = 1'b0;
			errors    = 0;
		endfunction

		function void write_reg(reg_idx_t idx, cfg_data_t data);
			case (idx)
				REG_SHEAR: shear_mod = data;
				REG_BULK:  bulk_mod  = data;
				REG_SPLIT: split_on  = data[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return due_responses.size();
		endfunction

		// Round Q.54 half up to Q.16, clamp to 48 signed bits.
		function stress_t round_stress(logic signed [127:0] v);
			v = (v + 128'sh20_0000_0000) >>> 38;
			if (v > 128'sh7FFF_FFFF_FFFF)
				return STRESS_MAX;
			if (v < -128'sh8000_0000_0000)
				return STRESS_MIN;
			return v[47:0];
		endfunction

		function response_t split_stress_energy(point_t p);
			longint              e [6];
			longint              dev [3];
			longint              tr, n, q;
			logic signed [127:0] gm, km, gw, cv, c2, tw, w, en;
			response_t           r;
			for (int i = 0; i < 6; i++)
				e[i] = p.strain[i];
			tr = e[0] + e[1] + e[2];
			// tr/3 to the nearest Q.30 step: floor((tr + 1) / 3)
			n = tr + 1;
			q = n / 3;
			if (n < 0 && n % 3 != 0)
				q = q - 1;
			for (int i = 0; i < 3; i++)
				dev[i] = e[i] - q;

			gm = shear_mod;
			km = bulk_mod;
			gw = p.degr;
			tw = tr;
			if (split_on && tr <= 0)
				cv = km <<< 16;
			else
				cv = gw * km;
			c2 = 2 * gw * gm;

			for (int i = 0; i < 3; i++) begin
				w = dev[i];
				r.stress[i] = round_stress(cv * tw + c2 * w);
			end
			for (int i = 3; i < 6; i++) begin
				w = e[i];
				r.stress[i] = round_stress(c2 * w);
			end

			// dev:dev in Q.60, shear entries counted twice
			en = 0;
			for (int i = 0; i < 3; i++) begin
				w = dev[i];
				en = en + w * w;
			end
			for (int i = 3; i < 6; i++) begin
				w = e[i];
				en = en + 2 * w * w;
			end
			en = en * 2 * gm;
			if (tr > 0)
				en = en + tw * tw * km;
			en = (en + 128'sh10_0000_0000_0000) >>> 53;
			if (en > 128'shFFFF_FFFF_FFFF)
				r.energy = '1;
			else
				r.energy = en[47:0];
			if (r.energy < p.old_energy)
				r.energy = p.old_energy;
			return r;
		endfunction

		function void note_point(point_t p);
			due_responses.push_back(split_stress_energy(p));
		endfunction

		function void flag(string name, longint want, longint got);
			if (errors < REPORT_CAP)
				$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		endfunction

		function void check_response(response_t got);
			response_t want;
			string     names [6];
			names = '{"stress_xx", "stress_yy", "stress_zz",
				"stress_xy", "stress_yz", "stress_xz"};
			if (due_responses.size() == 0) begin
				if (errors < REPORT_CAP)
					$error("result transfer with no point outstanding");
				errors++;
				return;
			end
			want = due_responses.pop_front();
			for (int i = 0; i < 6; i++)
				if (got.stress[i] !== want.stress[i])
					flag(names[i], want.stress[i], got.stress[i]);
			if (got.energy !== want.energy)
				flag("energy", want.energy, got.energy);
		endfunction

	endclass

endpackage

>>> tb/sv/split_elastic_stress_energy_tb.sv
// ----------------------------------------------------------------------------
// split_elastic_stress_energy testbench
// Drives quadrature points through the split stress block under several
// moduli settings and idle patterns, and checks every stress component and
// the history-maxed energy against an in-bench computation.
// ----------------------------------------------------------------------------
module split_elastic_stress_energy_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ses_pkg::*;
	import stress_energy_scoreboard_pkg::*;

	localparam int       CYCLE_LIMIT = 400000;
	localparam int       RANDOM_PER_SET = 272;
	localparam int       HOLD_AT = 300;       // points sent before the long hold-off
	localparam int       HOLD_LEN = 64;       // cycles of the hold-off
	localparam reg_idx_t REG_SPARE = 2'd3;    // unmapped register index
	localparam strain_t  S_MAX = 32'sh7FFF_FFFF;
	localparam strain_t  S_MIN = 32'sh8000_0000;
	localparam strain_t  S_HALF = 32'sh2000_0000;
	localparam strain_t  S_QUART = 32'sh1000_0000;
	localparam degr_t    G_ONE = 17'd65536;
	localparam degr_t    G_TOP = 17'h1FFFF;
	localparam energy_t  E_TOP = 48'hFFFF_FFFF_FFFF;

	logic       clk;
	logic       arst_n;
	logic       cfg_write;
	reg_idx_t   cfg_index;
	cfg_data_t  cfg_data;
	logic       point_valid;
	logic       point_stall;
	strain_t    strain_xx, strain_yy, strain_zz, strain_xy, strain_yz, strain_xz;
	degr_t      degradation;
	energy_t    old_energy;
	logic       result_valid;
	logic       result_stall = 1'b0;
	stress_t    stress_xx, stress_yy, stress_zz, stress_xy, stress_yz, stress_xz;
	energy_t    energy;

	stress_energy_scoreboard sb = new();

	int send_idle_pct = 13;
	int recv_idle_pct = 75;
	int points_sent = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int cycle_count = 0;

	split_elastic_stress_energy dut (.*);

	always #1 clk = ~clk;

	// Abort a run that hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: pick the stall at the falling edge. Once enough points have
	// gone in, hold off for a long stretch so the pipeline fills and pushes
	// back on the point channel.
	always @(negedge clk) begin
		if (!hold_done && points_sent >= HOLD_AT) begin
			hold_left = HOLD_LEN;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Check every result transfer at the rising edge.
	always @(posedge clk) begin
		response_t got;
		if (arst_n && result_valid && !result_stall) begin
			got.stress = '{stress_xx, stress_yy, stress_zz, stress_xy, stress_yz, stress_xz};
			got.energy = energy;
			sb.check_response(got);
		end
	end

	// Hold the point on the port until the block takes it, then note it.
	task automatic send_point(input point_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			point_valid <= 1'b0;
			@(negedge clk);
		end
		point_valid <= 1'b1;
		strain_xx <= p.strain[0];
		strain_yy <= p.strain[1];
		strain_zz <= p.strain[2];
		strain_xy <= p.strain[3];
		strain_yz <= p.strain[4];
		strain_xz <= p.strain[5];
		degradation <= p.degr;
		old_energy <= p.old_energy;
		do
			@(posedge clk);
		while (point_stall);
		sb.note_point(p);
		points_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input cfg_data_t data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	// Load all three registers plus a stray write to the unmapped index,
	// which must leave them alone. Upper bits of the split word are junk.
	task automatic load_moduli(input modulus_t g_mod, input modulus_t k_mod,
			input logic split);
		write_reg(REG_SHEAR, g_mod);
		write_reg(REG_SPARE, $urandom);
		write_reg(REG_BULK, k_mod);
		write_reg(REG_SPLIT, {31'($urandom), split});
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Drop the point valid, wait until every expected result is back, then
	// let the pipe settle.
	task automatic drain();
		point_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SES_DEPTH + 2) @(negedge clk);
	endtask

	function automatic point_t mk_point(input strain_t xx, input strain_t yy,
			input strain_t zz, input strain_t xy, input strain_t yz, input strain_t xz,
			input degr_t g, input energy_t old);
		point_t p;
		p.strain = '{xx, yy, zz, xy, yz, xz};
		p.degr = g;
		p.old_energy = old;
		return p;
	endfunction

	// Spread magnitudes: rails, full range and scaled-down realistic strains.
	function automatic strain_t rand_strain();
		strain_t s;
		s = $urandom;
		case ($urandom_range(7))
			0: s = S_MAX;
			1: s = S_MIN;
			2, 3: ;
			default: s = s >>> $urandom_range(1, 20);
		endcase
		return s;
	endfunction

	function automatic point_t rand_point();
		point_t p;
		longint zz;
		foreach (p.strain[i])
			p.strain[i] = rand_strain();
		// Force a zero trace now and then.
		if ($urandom_range(7) == 0) begin
			zz = -(longint'(p.strain[0]) + longint'(p.strain[1]));
			if (zz >= -64'sd2147483648 && zz <= 64'sd2147483647)
				p.strain[2] = strain_t'(zz);
		end
		case ($urandom_range(9))
			0: p.degr = '0;
			1: p.degr = G_ONE;
			2: p.degr = degr_t'($urandom_range(65537, 131071));
			default: p.degr = degr_t'($urandom_range(0, 65536));
		endcase
		case ($urandom_range(5))
			0: p.old_energy = '0;
			1: p.old_energy = E_TOP;
			2, 3: p.old_energy = energy_t'({$urandom, $urandom});
			default: p.old_energy = energy_t'($urandom) >> $urandom_range(0, 31);
		endcase
		return p;
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_SHEAR;
		cfg_data = '0;
		point_valid = 1'b0;
		strain_xx = '0;
		strain_yy = '0;
		strain_zz = '0;
		strain_xy = '0;
		strain_yz = '0;
		strain_xz = '0;
		degradation = '0;
		old_energy = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed points, split on with moderate moduli.
		load_moduli(32'h0123_4567, 32'h0345_6789, 1'b1);
		send_point(mk_point(0, 0, 0, 0, 0, 0, G_ONE, 0));
		send_point(mk_point(S_MAX, S_MAX, S_MAX, 0, 0, 0, G_ONE, 0));
		// compressive, fully broken: volumetric stays undegraded
		send_point(mk_point(S_MIN, S_MIN, S_MIN, 0, 0, 0, 0, 0));
		send_point(mk_point(0, 0, 0, S_MIN, S_MAX, S_MIN, G_ONE, 0));
		// zero trace counts as not positive
		send_point(mk_point(S_HALF, -S_HALF, 0, 32'sh10_0000, -32'sh10_0000, 0,
			17'd32768, 0));
		// degradation above one
		send_point(mk_point(32'sh200_0000, 32'sh100_0000, -32'sh80_0000,
			32'sh40_0000, 32'sh20_0000, 32'sh10_0000, G_TOP, 0));
		send_point(mk_point(32'sh200_0000, 32'sh100_0000, -32'sh80_0000,
			32'sh40_0000, 32'sh20_0000, 32'sh10_0000, 17'd65537, 0));
		// energy below history
		send_point(mk_point(1000, 2000, 3000, 4000, 5000, 6000, G_ONE, E_TOP));
		// trace of one and two either way: rounding of tr/3
		send_point(mk_point(1, 0, 0, 0, 0, 0, G_ONE, 0));
		send_point(mk_point(-1, 0, 0, 0, 0, 0, G_ONE, 0));
		send_point(mk_point(2, 0, 0, 0, 0, 0, G_ONE, 0));
		send_point(mk_point(0, 0, -2, 0, 0, 0, G_ONE, 0));
		send_point(mk_point(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, G_TOP, E_TOP));
		send_point(mk_point(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, G_TOP, 0));
		send_point(mk_point(-S_QUART, -S_QUART, -S_QUART, 0, 0, 0, 17'd16384, 0));

		// Directed points at the top moduli, split off: saturation both ways.
		drain();
		load_moduli('1, '1, 1'b0);
		send_point(mk_point(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, G_TOP, 0));
		send_point(mk_point(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, G_TOP, 0));
		send_point(mk_point(-S_QUART, -S_QUART, -S_QUART, 0, 0, 0, 17'd16384, 0));
		send_point(mk_point(S_HALF, -S_HALF, 0, 0, 0, 0, G_ONE, 0));
		send_point(mk_point(S_MAX, S_MIN, 0, S_MIN, S_MAX, 0, 0, E_TOP));

		// Random sets: two per idle pattern, each under its own moduli.
		for (int set = 0; set < 6; set++) begin
			drain();
			case (set / 2)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct = 75;
				end
				1: begin
					send_idle_pct = 75;
					recv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (set)
				0: load_moduli($urandom >> 4, $urandom >> 4, 1'b1);
				1: load_moduli('1, '1, 1'b0);
				2: load_moduli('0, '0, 1'b1);
				3: load_moduli($urandom, $urandom, 1'b0);
				4: load_moduli($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20), 1'b1);
				default: load_moduli($urandom, $urandom, 1'($urandom));
			endcase
			repeat (RANDOM_PER_SET) send_point(rand_point());
		end
		point_valid <= 1'b0;

		// Drain the tail and give stray results a chance to show up.
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SES_DEPTH * 4) @(negedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
